### hdl/stereo_flanger_top_assert.svh
// ----------------------------------------------------------------------------
// stereo_flanger_top_assert.svh
// Assertion macros for the flanger checker.
// ----------------------------------------------------------------------------
`ifndef STEREO_FLANGER_TOP_ASSERT_SVH
`define STEREO_FLANGER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define SFL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("flanger check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define SFL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("flanger check failed");

`endif

### hdl/sfl_pkg.sv
// ----------------------------------------------------------------------------
// sfl_pkg
// Shared types and constants of the stereo flanger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfl_pkg;

	// audio channels carried by one frame word
	localparam int CHANNELS = 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LIMIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WET_LEFT      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WET_RIGHT     = 3'd6;

	// register values after reset
	localparam logic [17:0]        BASE_DELAY_RST    = 18'd11546;
	localparam logic [15:0]        SWEEP_STEP_RST    = 16'd212;
	localparam logic [16:0]        SWEEP_LIMIT_RST   = 17'd56448;
	localparam logic signed [15:0] FEEDBACK_GAIN_RST = 16'sd24576;
	localparam logic [15:0]        MIX_GAIN_RST      = 16'd32768;
	localparam logic [15:0]        WET_RST           = 16'd32768;

	// unity gain in Q1.15
	localparam logic [15:0] GAIN_ONE = 16'd32768;

	// one-hot step strobes from the sequencer
	typedef struct packed {
		logic start;   // frame word accepted
		logic modify;  // feedback write, sweep update, delay wrap
		logic locate;  // tap addresses
		logic read;    // memory read of both taps
		logic tap;     // interpolation
	} sfl_ctl_t;

endpackage

`default_nettype wire

### hdl/sfl_addr.sv
// ----------------------------------------------------------------------------
// sfl_addr
// Write position, fill count, triangle sweep and tap address generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfl_addr #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sfl_pkg::sfl_ctl_t ctl,
	input  logic [17:0]       base_delay,
	input  logic [15:0]       sweep_step,
	input  logic [16:0]       sweep_limit,
	output logic [AW-1:0]     wp,
	output logic [AW-1:0]     i1,
	output logic [AW-1:0]     i2,
	output logic [7:0]        frac,
	output logic              v1,
	output logic              v2
);
	import sfl_pkg::*;

	localparam int SPAN = DEPTH * 256;
	localparam int DW   = 19;
	localparam int DMAX = 2 * (2 ** 18 - 1);
	localparam int NMUL = DMAX / SPAN;
	localparam int PW   = (AW + 9 > DW + 1) ? AW + 9 : DW + 1;

	logic [AW-1:0]   wp_q;
	logic [AW:0]     fill_q;
	logic [25:0]     sweep_q;
	logic            falling_q;
	logic [DW-1:0]   delay_s1;
	logic [DW-1:0]   dm_s2;
	logic [DW-1:0]   dm;
	logic [PW-1:0]   ep_raw;
	logic [PW-1:0]   ep;
	logic [AW-1:0]   ei;
	logic [AW-1:0]   i1_q, i2_q;
	logic [AW-1:0]   i1_d, i2_d;
	logic [7:0]      frac_q;
	logic            v1_q, v2_q;
	logic            full;
	logic [27:0]     sw_nxt;
	logic [27:0]     sw_lim;
	logic            sw_le0, sw_ge;

	assign full = (fill_q == (AW+1)'(DEPTH));

	// position advance and fill count at frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (ctl.start) begin
			wp_q   <= (wp_q >= AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			fill_q <= full ? fill_q : fill_q + 1'b1;
		end
	end

	// delay seen by this frame
	always_ff @(posedge clk) begin
		if (ctl.start)
			delay_s1 <= DW'(base_delay) + DW'(sweep_q[25:8]);
	end

	// fold the delay into one line length: compares against constant multiples
	always_comb begin
		dm = delay_s1;
		for (int k = 1; k <= NMUL; k++) begin
			if (delay_s1 >= DW'(k * SPAN))
				dm = delay_s1 - DW'(k * SPAN);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.modify)
			dm_s2 <= dm;
	end

	// triangle sweep, moved once per frame after its delay was taken, frozen while the step is zero
	assign sw_nxt = falling_q ? (28'(sweep_q) - 28'(sweep_step))
	                          : (28'(sweep_q) + 28'(sweep_step));
	assign sw_lim = {3'd0, sweep_limit, 8'd0};
	assign sw_le0 = sw_nxt[27] || (sw_nxt == '0);
	assign sw_ge  = !sw_nxt[27] && (sw_nxt >= sw_lim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q   <= '0;
			falling_q <= 1'b0;
		end else if (ctl.modify && (sweep_step != '0)) begin
			if (sw_le0) begin
				sweep_q   <= '0;
				falling_q <= !falling_q;
			end else begin
				if (sw_ge)
					falling_q <= !falling_q;
				sweep_q <= (sw_nxt > 28'h3FF_FFFF) ? 26'h3FF_FFFF : sw_nxt[25:0];
			end
		end
	end

	// read position behind the write position, wrapped into the line
	assign ep_raw = PW'({wp_q, 8'd0}) - PW'(dm_s2);
	assign ep     = ep_raw[PW-1] ? ep_raw + PW'(SPAN) : ep_raw;
	assign ei     = ep[AW+7:8];

	always_comb begin
		i1_d = (ei == AW'(DEPTH - 1)) ? '0 : ei + AW'(1);
		if (ei == AW'(DEPTH - 2))
			i2_d = '0;
		else if (ei == AW'(DEPTH - 1))
			i2_d = AW'(1);
		else
			i2_d = ei + AW'(2);
	end

	// entries not yet written since reset read as silence
	always_ff @(posedge clk) begin
		if (ctl.locate) begin
			i1_q   <= i1_d;
			i2_q   <= i2_d;
			frac_q <= ep[7:0];
			v1_q   <= full || ((i1_d != '0) && ({1'b0, i1_d} <= fill_q));
			v2_q   <= full || ((i2_d != '0) && ({1'b0, i2_d} <= fill_q));
		end
	end

	assign wp   = wp_q;
	assign i1   = i1_q;
	assign i2   = i2_q;
	assign frac = frac_q;
	assign v1   = v1_q;
	assign v2   = v2_q;

endmodule

`default_nettype wire

### hdl/sfl_chan.sv
// ----------------------------------------------------------------------------
// sfl_chan
// One channel: delay line memory, feedback write, interpolated tap, output mix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfl_chan #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sfl_pkg::sfl_ctl_t  ctl,
	input  logic signed [15:0] x,
	input  logic signed [15:0] fb_gain,
	input  logic [15:0]        wet,
	input  logic [15:0]        dry,
	input  logic [15:0]        mix,
	input  logic [AW-1:0]      wp,
	input  logic [AW-1:0]      i1,
	input  logic [AW-1:0]      i2,
	input  logic [7:0]         frac,
	input  logic               v1,
	input  logic               v2,
	output logic signed [15:0] y
);
	import sfl_pkg::*;

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767)
			return 16'sh7FFF;
		else if (v < -48'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

	logic signed [15:0] mem [DEPTH];

	logic signed [15:0] last_q;
	logic signed [15:0] rd1_s3, rd2_s3;
	logic               v1_s3, v2_s3;
	logic signed [32:0] dx_s2;
	logic [31:0]        wm_s2;

	logic signed [31:0] fb_prod;
	logic signed [32:0] x_sc;
	logic signed [32:0] fb_acc;
	logic signed [15:0] wdata;
	logic signed [16:0] dry_sg;
	logic signed [32:0] dx;
	logic [31:0]        wm;

	logic signed [15:0] d1, d2;
	logic signed [9:0]  w1_sg, w2_sg;
	logic signed [25:0] p1, p2;
	logic signed [26:0] tap_acc;
	logic signed [15:0] tap;

	logic signed [32:0] wm_sg;
	logic signed [47:0] mp;
	logic signed [47:0] dx_sc;
	logic signed [47:0] mix_acc;

	// feedback write: round(x*2^15 + fb*last) >> 15, saturated
	assign fb_prod = fb_gain * last_q;
	assign x_sc    = {{2{x[15]}}, x, 15'd0};
	assign fb_acc  = x_sc + {fb_prod[31], fb_prod} + 33'sd16384;
	assign wdata   = sat16({{30{fb_acc[32]}}, fb_acc[32:15]});

	// dry and wet coefficients for the output mix
	assign dry_sg = {1'b0, dry};
	assign dx     = dry_sg * x;
	assign wm     = wet * mix;

	// write port; taps are read in the read step after the address step, so no forwarding needed
	always_ff @(posedge clk) begin
		if (ctl.modify) begin
			mem[wp] <= wdata;
			dx_s2   <= dx;
			wm_s2   <= wm;
		end
	end

	// two read ports, registered data
	always_ff @(posedge clk) begin
		if (ctl.read) begin
			rd1_s3 <= mem[i1];
			rd2_s3 <= mem[i2];
			v1_s3  <= v1;
			v2_s3  <= v2;
		end
	end

	// linear interpolation between the two taps
	assign d1      = v1_s3 ? rd1_s3 : '0;
	assign d2      = v2_s3 ? rd2_s3 : '0;
	assign w1_sg   = {1'b0, 9'd256 - {1'b0, frac}};
	assign w2_sg   = {2'b00, frac};
	assign p1      = d1 * w1_sg;
	assign p2      = d2 * w2_sg;
	assign tap_acc = p1 + p2 + 27'sd128;
	assign tap     = sat16({{29{tap_acc[26]}}, tap_acc[26:8]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_q <= '0;
		else if (ctl.tap)
			last_q <= tap;
	end

	// output: round(dry*x*2^15 + wet*mix*tap) >> 45, saturated
	assign wm_sg   = {1'b0, wm_s2};
	assign mp      = wm_sg * last_q;
	assign dx_sc   = {dx_s2, 15'd0};
	assign mix_acc = dx_sc + mp + 48'sd17592186044416;
	assign y       = sat16({{45{mix_acc[47]}}, mix_acc[47:45]});

endmodule

`default_nettype wire

### hdl/stereo_flanger_top.sv
// ----------------------------------------------------------------------------
// stereo_flanger_top: stereo flanger, fractional delay with triangle sweep.
// The sequencer steps each frame through write, address, dual-port read,
//   interpolate and mix; input is stalled until the frame has left mix, and
//   mix waits while a held output word is stalled by out_stall.
// Reset: registers to defaults; delay lines read as silence via a fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_flanger_top #(
	parameter int LINE_DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [15:0]             left_sample,
	input  logic signed [15:0]             right_sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [15:0]             left_out,
	output logic signed [15:0]             right_out,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sfl_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_ADDR = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_TAP  = 3'd4;
	localparam logic [2:0] ST_MIX  = 3'd5;

	logic [2:0]         state_q, state_d;
	logic               in_acc;
	logic               mix_fire;
	sfl_ctl_t           ctl;

	logic [17:0]        base_q;
	logic [15:0]        step_q;
	logic [16:0]        limit_q;
	logic signed [15:0] fb_q;
	logic [15:0]        mix_q;
	logic [15:0]        wetl_q, wetr_q;
	logic [15:0]        mix_cap;

	logic signed [15:0] x_in  [CHANNELS];
	logic signed [15:0] x_q   [CHANNELS];
	logic [15:0]        wet_raw [CHANNELS];
	logic [15:0]        wet_cap [CHANNELS];
	logic [15:0]        dry     [CHANNELS];
	logic signed [15:0] y       [CHANNELS];
	logic signed [15:0] out_q   [CHANNELS];
	logic               out_valid_q;

	logic [AW-1:0]      wp, i1, i2;
	logic [7:0]         frac;
	logic               v1, v2;

	// configuration writes, taken at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_DELAY_RST;
			step_q  <= SWEEP_STEP_RST;
			limit_q <= SWEEP_LIMIT_RST;
			fb_q    <= FEEDBACK_GAIN_RST;
			mix_q   <= MIX_GAIN_RST;
			wetl_q  <= WET_RST;
			wetr_q  <= WET_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE_DELAY:    base_q  <= cfg_data;
				REG_SWEEP_STEP:    step_q  <= cfg_data[15:0];
				REG_SWEEP_LIMIT:   limit_q <= cfg_data[16:0];
				REG_FEEDBACK_GAIN: fb_q    <= cfg_data[15:0];
				REG_MIX_GAIN:      mix_q   <= cfg_data[15:0];
				REG_WET_LEFT:      wetl_q  <= cfg_data[15:0];
				REG_WET_RIGHT:     wetr_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// gains above one act as one
	assign mix_cap    = (mix_q > GAIN_ONE) ? GAIN_ONE : mix_q;
	assign wet_raw[0] = wetl_q;
	assign wet_raw[1] = wetr_q;
	assign x_in[0]    = left_sample;
	assign x_in[1]    = right_sample;

	// sequencer
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign mix_fire = (state_q == ST_MIX) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_MOD;
			ST_MOD:  state_d = ST_ADDR;
			ST_ADDR: state_d = ST_READ;
			ST_READ: state_d = ST_TAP;
			ST_TAP:  state_d = ST_MIX;
			ST_MIX:  if (mix_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign ctl.start  = in_acc;
	assign ctl.modify = (state_q == ST_MOD);
	assign ctl.locate = (state_q == ST_ADDR);
	assign ctl.read   = (state_q == ST_READ);
	assign ctl.tap    = (state_q == ST_TAP);

	// input word capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int c = 0; c < CHANNELS; c++)
				x_q[c] <= x_in[c];
		end
	end

	sfl_addr #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW)
	) u_addr (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.base_delay  (base_q),
		.sweep_step  (step_q),
		.sweep_limit (limit_q),
		.wp          (wp),
		.i1          (i1),
		.i2          (i2),
		.frac        (frac),
		.v1          (v1),
		.v2          (v2)
	);

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		assign wet_cap[c] = (wet_raw[c] > GAIN_ONE) ? GAIN_ONE : wet_raw[c];
		assign dry[c]     = GAIN_ONE - wet_cap[c];

		sfl_chan #(
			.DEPTH (LINE_DEPTH),
			.AW    (AW)
		) u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.x       (x_q[c]),
			.fb_gain (fb_q),
			.wet     (wet_cap[c]),
			.dry     (dry[c]),
			.mix     (mix_cap),
			.wp      (wp),
			.i1      (i1),
			.i2      (i2),
			.frac    (frac),
			.v1      (v1),
			.v2      (v2),
			.y       (y[c])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (mix_fire)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (mix_fire) begin
			for (int c = 0; c < CHANNELS; c++)
				out_q[c] <= y[c];
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = out_q[0];
	assign right_out = out_q[1];

endmodule

`default_nettype wire

### hdl/sfl_check.sv
// ----------------------------------------------------------------------------
// sfl_check
// Port-level checks of the flanger: busy after accept, words in flight and output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_flanger_top_assert.svh"

module sfl_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] left_out,
	input logic signed [15:0] right_out
);
	logic       in_acc, out_acc;
	logic [1:0] pending_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// words taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (in_acc && !out_acc)
			pending_q <= pending_q + 2'd1;
		else if (!in_acc && out_acc)
			pending_q <= pending_q - 2'd1;
	end

	`SFL_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall)
	`SFL_ASSERT_NOW(a_no_invented_word, out_valid, pending_q != 2'd0)
	`SFL_ASSERT_NOW(a_one_in_flight, in_acc,
		(pending_q == 2'd0) || ((pending_q == 2'd1) && out_valid))
	`SFL_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(left_out) && $stable(right_out))

endmodule

bind stereo_flanger_top sfl_check u_sfl_check (.*);

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the stereo flanger
// Frames go in with random gaps while the output side stalls at random. A
// behavioral model of the flanger (delay lines, triangle sweep, interpolated
// taps, feedback and wet/dry mix) predicts every output word, and each word is
// compared per channel. Registers are rewritten only while the block is idle.
// ----------------------------------------------------------------------------

module tb_top;
	import sfl_pkg::*;

	localparam int LINE_DEPTH     = 1024;
	localparam int LATENCY        = 6;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES  = 9;
	localparam int PHASE_FRAMES   = 100;
	localparam longint SWEEP_MAX  = 64'd67108863;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// model copy of the registers
	logic [17:0] base_delay;
	logic [15:0] sweep_step;
	logic [16:0] sweep_limit;
	logic signed [15:0] fb_gain;
	logic [15:0] mix_gain;
	logic [15:0] wet_l;
	logic [15:0] wet_r;

	// model copy of the state
	logic signed [15:0] dline [2][LINE_DEPTH];
	logic signed [15:0] last_tap [2];
	int wr_pos;
	logic [25:0] sweep_pos;
	logic sweep_down;

	frame_t frames_expected[$];
	int error_count = 0;
	int words_out = 0;
	int idle_cycles = 0;

	// idling controls
	bit tx_gap_en = 1'b0;
	bit rx_hold_en = 1'b0;
	int stall_left = 0;
	int free_left = 0;

	stereo_flanger_top #(
		.LINE_DEPTH(LINE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_out(left_out),
		.right_out(right_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic signed [15:0] sat16(longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// one channel: feedback write, interpolated tap, wet/dry mix
	function automatic logic signed [15:0] flange_channel(int ch, logic signed [15:0] x,
			logic [15:0] wet, longint i1, longint i2, longint frac);
		longint acc;
		longint w;
		longint dry;
		longint mix;
		logic signed [15:0] tap;
		w = (wet > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(wet);
		dry = 32768 - w;
		mix = (mix_gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(mix_gain);
		acc = longint'(x) * 32768 + longint'(fb_gain) * longint'(last_tap[ch]);
		dline[ch][wr_pos] = sat16((acc + (64'sd1 << 14)) >>> 15);
		acc = longint'(dline[ch][i1]) * (256 - frac) + longint'(dline[ch][i2]) * frac;
		tap = sat16((acc + 128) >>> 8);
		last_tap[ch] = tap;
		acc = dry * longint'(x) * 32768 + w * mix * longint'(tap);
		return sat16((acc + (64'sd1 << 44)) >>> 45);
	endfunction

	// advances the model by one frame and returns the output word it causes
	function automatic frame_t flanger_predict(frame_t din);
		longint span;
		longint dly;
		longint ep;
		longint i1;
		longint i2;
		longint frac;
		longint s;
		frame_t r;
		span = longint'(LINE_DEPTH) * 256;
		wr_pos = (wr_pos >= LINE_DEPTH - 1) ? 0 : wr_pos + 1;
		dly = longint'(base_delay) + longint'(sweep_pos[25:8]);
		ep = (longint'(wr_pos) * 256 + 8 * span - dly) % span;
		frac = ep % 256;
		i1 = ep / 256 + 1;
		if (i1 >= LINE_DEPTH)
			i1 = 0;
		i2 = i1 + 1;
		if (i2 >= LINE_DEPTH)
			i2 = 0;
		r.left = flange_channel(0, din.left, wet_l, i1, i2, frac);
		r.right = flange_channel(1, din.right, wet_r, i1, i2, frac);
		// triangle sweep, frozen when the step is zero
		if (sweep_step != 0) begin
			s = longint'(sweep_pos);
			s = sweep_down ? s - longint'(sweep_step) : s + longint'(sweep_step);
			if (s <= 0) begin
				s = 0;
				sweep_down = !sweep_down;
			end else if (s >= longint'(sweep_limit) * 256) begin
				sweep_down = !sweep_down;
			end
			if (s > SWEEP_MAX)
				s = SWEEP_MAX;
			sweep_pos = s[25:0];
		end
		return r;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_BASE_DELAY:    base_delay = d[17:0];
			REG_SWEEP_STEP:    sweep_step = d[15:0];
			REG_SWEEP_LIMIT:   sweep_limit = d[16:0];
			REG_FEEDBACK_GAIN: fb_gain = d[15:0];
			REG_MIX_GAIN:      mix_gain = d[15:0];
			REG_WET_LEFT:      wet_l = d[15:0];
			REG_WET_RIGHT:     wet_r = d[15:0];
			default: ;
		endcase
	endfunction

	function automatic void note_error(string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic int pick_gap();
		int r;
		if (!tx_gap_en)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 0;
		if (r < 17)
			return $urandom_range(1, 5);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 511) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return GAIN_ONE;
			2: return 16'($urandom_range(32769, 65535));
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	// sends one frame word and records the output word it must produce
	task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r);
		int gap;
		frame_t w;
		frame_t pred;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		w.left = l;
		w.right = r;
		pred = flanger_predict(w);
		frames_expected.insert(frames_expected.size(), pred);
	endtask

	// drop valid and wait until every predicted word has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (frames_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_extremes(input int n);
		int k;
		for (k = 0; k < n; k++) begin
			case (k % 6)
				0: send_frame(16'h7FFF, 16'h8000);
				1: send_frame(16'h8000, 16'h7FFF);
				2: send_frame(16'h0000, 16'h0000);
				3: send_frame(16'hFFFF, 16'h0001);
				4: send_frame(16'h7FFF, 16'h7FFF);
				default: send_frame(16'h8000, 16'h8000);
			endcase
		end
	endtask

	// reset values, no idling
	task automatic test_defaults();
		tx_gap_en = 1'b0;
		rx_hold_en = 1'b0;
		send_extremes(6);
	endtask

	// shortest and aliased delays, gains past one, frozen sweep, feedback extremes
	task automatic test_register_extremes();
		tx_gap_en = 1'b1;
		rx_hold_en = 1'b1;
		wait_drained();
		write_reg(REG_BASE_DELAY, 18'd256);
		write_reg(REG_SWEEP_STEP, 18'h0FFFF);
		write_reg(REG_SWEEP_LIMIT, 18'd0);
		write_reg(REG_FEEDBACK_GAIN, 18'h38000);
		write_reg(REG_MIX_GAIN, 18'h3FFFF);
		write_reg(REG_WET_LEFT, 18'd0);
		write_reg(REG_WET_RIGHT, 18'h0FFFF);
		send_extremes(6);
		wait_drained();
		write_reg(REG_BASE_DELAY, 18'h3FFFF);
		write_reg(REG_SWEEP_STEP, 18'h30000);
		write_reg(REG_SWEEP_LIMIT, 18'h1FFFF);
		write_reg(REG_FEEDBACK_GAIN, 18'h07FFF);
		write_reg(REG_MIX_GAIN, 18'd0);
		write_reg(REG_WET_LEFT, 18'(GAIN_ONE));
		write_reg(REG_WET_RIGHT, 18'd16384);
		send_extremes(5);
	endtask

	// turnarounds at the limit, and again after the limit is lowered
	task automatic test_sweep_turnaround();
		int k;
		wait_drained();
		write_reg(REG_BASE_DELAY, 18'd1000);
		write_reg(REG_MIX_GAIN, 18'(GAIN_ONE));
		write_reg(REG_SWEEP_LIMIT, 18'd4);
		write_reg(REG_SWEEP_STEP, 18'd300);
		write_reg(REG_NONE, 18'h2AAAA);
		for (k = 0; k < 6; k++)
			send_frame(pick_sample(), pick_sample());
		wait_drained();
		write_reg(REG_SWEEP_LIMIT, 18'd1);
		for (k = 0; k < 3; k++)
			send_frame(pick_sample(), pick_sample());
	endtask

	// random settings per phase, random frames in between
	task automatic test_random_phases();
		int ph;
		int k;
		int first;
		int pause_at;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] d;
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			tx_gap_en = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
			rx_hold_en = (ph == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
			first = $urandom_range(0, 6);
			for (k = 0; k < 7; k++) begin
				idx = 3'((first + k) % 7);
				d = 18'($urandom);
				case (idx)
					REG_BASE_DELAY: begin
						case ($urandom_range(0, 9))
							0: d = 18'd256;
							1: d = 18'h3FFFF;
							2: d = 18'($urandom_range(0, 255));
							3, 4: d = 18'($urandom_range(256, 4096));
							default: d = 18'($urandom_range(256, 262143));
						endcase
					end
					REG_SWEEP_STEP: begin
						case ($urandom_range(0, 9))
							0: d[15:0] = 16'd0;
							1: d[15:0] = 16'hFFFF;
							default: d[15:0] = 16'($urandom);
						endcase
					end
					REG_SWEEP_LIMIT: begin
						case ($urandom_range(0, 9))
							0: d[16:0] = 17'd0;
							1: d[16:0] = 17'h1FFFF;
							2, 3, 4: d[16:0] = 17'($urandom_range(0, 64));
							5, 6: d[16:0] = 17'($urandom_range(0, 4096));
							default: d[16:0] = 17'($urandom);
						endcase
					end
					REG_FEEDBACK_GAIN: begin
						case ($urandom_range(0, 7))
							0: d[15:0] = 16'h8000;
							1: d[15:0] = 16'h7FFF;
							default: d[15:0] = 16'($urandom);
						endcase
					end
					default: d[15:0] = pick_gain();
				endcase
				write_reg(idx, d);
			end
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_NONE, 18'($urandom));
			// mid-phase the sender holds off until everything is back
			pause_at = $urandom_range(10, PHASE_FRAMES - 10);
			for (k = 0; k < PHASE_FRAMES; k++) begin
				if (k == pause_at)
					wait_drained();
				send_frame(pick_sample(), pick_sample());
			end
		end
	endtask

	// output side: random stall runs, mostly short
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (free_left > 0 || !rx_hold_en) begin
			if (free_left > 0)
				free_left--;
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
			case ($urandom_range(0, 19)) inside
				[0:11]: free_left = $urandom_range(0, 6);
				[12:17]: stall_left = $urandom_range(1, 4);
				default: stall_left = $urandom_range(15, 50);
			endcase
		end
	end

	// compare each output word with the oldest prediction
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frames_expected.size() == 0) begin
				note_error($sformatf("unexpected output word %0d: left %0d right %0d",
					words_out, left_out, right_out));
			end else begin
				want = frames_expected.pop_front();
				if (left_out !== want.left)
					note_error($sformatf("word %0d left_out: expected %0d, got %0d",
						words_out, want.left, left_out));
				if (right_out !== want.right)
					note_error($sformatf("word %0d right_out: expected %0d, got %0d",
						words_out, want.right, right_out));
			end
			words_out++;
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		left_sample = '0;
		right_sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		base_delay = BASE_DELAY_RST;
		sweep_step = SWEEP_STEP_RST;
		sweep_limit = SWEEP_LIMIT_RST;
		fb_gain = FEEDBACK_GAIN_RST;
		mix_gain = MIX_GAIN_RST;
		wet_l = WET_RST;
		wet_r = WET_RST;
		foreach (dline[c, i])
			dline[c][i] = '0;
		last_tap[0] = '0;
		last_tap[1] = '0;
		wr_pos = 0;
		sweep_pos = '0;
		sweep_down = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_register_extremes();
		test_sweep_turnaround();
		test_random_phases();

		wait_drained();
		repeat (2 * LATENCY) @(posedge clk);
		if (error_count == 0 && frames_expected.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
